// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCTO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MCTO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCTO_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MCTO_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/mcto_pkg.sv
// ----------------------------------------------------------------------------
// mcto_pkg
// widths and register codes for the mip chain texel address block
// ----------------------------------------------------------------------------
package mcto_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BPP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIPS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BC     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOL    = 3'd6;

  // field widths
  localparam int BPP_W   = 8;
  localparam int DIM_W   = 15;
  localparam int DEPTH_W = 12;
  localparam int LVL_W   = 4;
  localparam int COORD_W = 14;
  localparam int SLICE_W = 11;
  localparam int OFF_W   = 56;
  localparam int ROW_W   = 19;

  // internal widths
  localparam int PITCH_W = 20;                 // ceil(32767*255/8) fits
  localparam int PH_W    = PITCH_W + DIM_W;    // pitch * height
  localparam int SZ_W    = PH_W + DEPTH_W;     // one level
  localparam int SUM_W   = SZ_W + 2;           // whole chain
  localparam int SPLIT_W = 25;                 // chain * slice split point
  localparam int LVL_N   = 1 << LVL_W;
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LVL_N - 1);

  typedef struct packed {
    logic [BPP_W-1:0]   bits_per_texel;
    logic [DIM_W-1:0]   base_width;
    logic [DIM_W-1:0]   base_height;
    logic [DEPTH_W-1:0] base_depth;
    logic [LVL_W-1:0]   mip_count;
    logic               block_compressed;
    logic               volume_mode;
  } cfg_regs_t;

endpackage

// File: rtl/mcto_cfg_if.sv
// ----------------------------------------------------------------------------
// mcto_cfg_if
// register write channel: index and data with valid/ready
// ----------------------------------------------------------------------------
interface mcto_cfg_if import mcto_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mcto_req_if.sv
// ----------------------------------------------------------------------------
// mcto_req_if
// texel request channel with valid/ready
// ----------------------------------------------------------------------------
interface mcto_req_if import mcto_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] texel_x;
  logic [COORD_W-1:0] texel_y;
  logic [SLICE_W-1:0] slice_index;
  logic [LVL_W-1:0]   mip_level;

  modport source (output valid, output texel_x, output texel_y, output slice_index,
                  output mip_level, input ready);
  modport sink   (input valid, input texel_x, input texel_y, input slice_index,
                  input mip_level, output ready);
endinterface

// File: rtl/mcto_rsp_if.sv
// ----------------------------------------------------------------------------
// mcto_rsp_if
// address result channel with valid/ready
// ----------------------------------------------------------------------------
interface mcto_rsp_if import mcto_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] byte_offset;
  logic [ROW_W-1:0] row_bytes;

  modport source (output valid, output byte_offset, output row_bytes, input ready);
  modport sink   (input valid, input byte_offset, input row_bytes, output ready);
endinterface

// File: rtl/mip_chain_texel_offset.sv
// ----------------------------------------------------------------------------
// mip_chain_texel_offset
// byte address and row pitch of a texel in a packed mipmap chain
// ----------------------------------------------------------------------------
// usage
//   cfg : register writes (index, data); always ready. each write restarts the
//         level table build, during which req is held not ready
//   req : one transaction per texel (x, y, slice, mip level)
//   rsp : one transaction per request, in order: byte_offset and row_bytes
// pipeline and throughput
//   a request passes the lookup, product, partial sum and output stages; one
//   transaction per cycle sustained while rsp is ready, once the level table
//   is built. after reset or a register write one shared multiplier chain
//   builds it in pitch, area, size and sum phases for each of sixteen levels
// reset
//   registers take their reset values and the table build starts at once
// stalls
//   the whole pipe, output register included, holds while rsp.valid is high and
//   rsp is not ready; req ready drops with it, so nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mip_chain_texel_offset import mcto_pkg::*; #(
  parameter int MAX_LEVELS = 15,
  parameter int MAX_DIM    = 16384
) (
  input  logic       clk,
  input  logic       rst,
  mcto_cfg_if.sink   cfg,
  mcto_req_if.sink   req,
  mcto_rsp_if.source rsp
);

  localparam int PFX_IW = (MAX_LEVELS + 1 > 1) ? $clog2(MAX_LEVELS + 1) : 1;
  localparam int CMP_W  = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;

  // table build phases
  localparam logic [1:0] PH_PITCH = 2'd0;
  localparam logic [1:0] PH_AREA  = 2'd1;
  localparam logic [1:0] PH_SIZE  = 2'd2;
  localparam logic [1:0] PH_ACCUM = 2'd3;

  cfg_regs_t regs;

  // table build control
  logic             busy;
  logic [LVL_W-1:0] seq_lvl;
  logic [1:0]       seq_phase;

  // table build datapath
  logic [PITCH_W-1:0] seq_pitch;
  logic [DIM_W-1:0]   seq_hl;
  logic [DEPTH_W-1:0] seq_dl;
  logic [PH_W-1:0]    seq_area;
  logic [SZ_W-1:0]    seq_size;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   chain_total;
  logic [PITCH_W-1:0] pitch_tab [LVL_N];
  logic [SUM_W-1:0]   pfx_tab [MAX_LEVELS + 1];

  // effective base dims
  logic [DIM_W-1:0]   w_clamp, h_clamp, w_eff, h_eff, w_sh, h_sh, wl, hl;
  logic [DEPTH_W-1:0] d_eff, d_sh, dl;
  logic [PITCH_W-1:0] pitch_calc;
  logic [SUM_W-1:0]   acc_next;
  logic [LVL_W:0]     lvl_ext, wr_ext, mc1, chain_levels, m_ext;
  logic [PFX_IW-1:0]  wr_idx, pidx;
  logic               cfg_wr;

  // item pipe
  logic                 adv;
  logic                 s1_valid, s2_valid, s3_valid, s4_valid;
  logic [COORD_W-1:0]   x_in, y_in;
  logic [COORD_W-1:0]   s1_x, s1_y;
  logic [SLICE_W-1:0]   s1_z;
  logic [PITCH_W-1:0]   s1_pitch, s2_pitch, s3_pitch;
  logic [SUM_W-1:0]     s1_pfx, s2_pfx;
  logic [COORD_W+PITCH_W-1:0]          s2_yp;
  logic [COORD_W+BPP_W-4:0]            s2_xb, s3_xb;
  logic [SPLIT_W+SLICE_W-1:0]          s2_zlo;
  logic [SUM_W-SPLIT_W+SLICE_W-1:0]    s2_zhi;
  logic [OFF_W-1:0]     s3_a, s3_b, s4_off;
  logic [ROW_W-1:0]     s4_row;

  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;

  // --------------------------------------------------------------------------
  // registers and table build control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.bits_per_texel   <= BPP_W'(32);
      regs.base_width       <= DIM_W'(1);
      regs.base_height      <= DIM_W'(1);
      regs.base_depth       <= DEPTH_W'(1);
      regs.mip_count        <= '0;
      regs.block_compressed <= 1'b0;
      regs.volume_mode      <= 1'b0;
      busy                  <= 1'b1;
      seq_lvl               <= '0;
      seq_phase             <= PH_PITCH;
    end else if (cfg_wr) begin
      case (cfg.index)
        REG_BPP:    regs.bits_per_texel   <= cfg.data[BPP_W-1:0];
        REG_WIDTH:  regs.base_width       <= cfg.data[DIM_W-1:0];
        REG_HEIGHT: regs.base_height      <= cfg.data[DIM_W-1:0];
        REG_DEPTH:  regs.base_depth       <= cfg.data[DEPTH_W-1:0];
        REG_MIPS:   regs.mip_count        <= cfg.data[LVL_W-1:0];
        REG_BC:     regs.block_compressed <= cfg.data[0];
        REG_VOL:    regs.volume_mode      <= cfg.data[0];
        default: begin
        end
      endcase
      // rebuild the table from scratch
      busy      <= 1'b1;
      seq_lvl   <= '0;
      seq_phase <= PH_PITCH;
    end else if (busy) begin
      seq_phase <= seq_phase + 2'd1;
      if (seq_phase == PH_ACCUM) begin
        if (seq_lvl == LVL_LAST) begin
          busy <= 1'b0;
        end else begin
          seq_lvl <= seq_lvl + LVL_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // level geometry for the level under construction
  // --------------------------------------------------------------------------
  always_comb begin
    w_clamp = (CMP_W'(regs.base_width) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                        : regs.base_width;
    h_clamp = (CMP_W'(regs.base_height) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                         : regs.base_height;
    // compressed formats count 4x4 blocks, rounded up
    if (regs.block_compressed) begin
      w_eff = DIM_W'(((DIM_W + 1)'(w_clamp) + (DIM_W + 1)'(3)) >> 2);
      h_eff = DIM_W'(((DIM_W + 1)'(h_clamp) + (DIM_W + 1)'(3)) >> 2);
    end else begin
      w_eff = w_clamp;
      h_eff = h_clamp;
    end
    d_eff = regs.volume_mode ? regs.base_depth : DEPTH_W'(1);

    // halve per level, clamp at one
    w_sh = w_eff >> seq_lvl;
    h_sh = h_eff >> seq_lvl;
    d_sh = d_eff >> seq_lvl;
    wl   = (w_sh == '0) ? DIM_W'(1) : w_sh;
    hl   = (h_sh == '0) ? DIM_W'(1) : h_sh;
    dl   = (d_sh == '0) ? DEPTH_W'(1) : d_sh;

    pitch_calc = PITCH_W'(((DIM_W + BPP_W + 1)'(wl) * (DIM_W + BPP_W + 1)'(regs.bits_per_texel)
                           + (DIM_W + BPP_W + 1)'(7)) >> 3);

    lvl_ext  = {1'b0, seq_lvl};
    wr_ext   = lvl_ext + (LVL_W + 1)'(1);
    wr_idx   = PFX_IW'(wr_ext);
    acc_next = ((seq_lvl == '0) ? '0 : acc) + SUM_W'(seq_size);

    mc1          = {1'b0, regs.mip_count} + (LVL_W + 1)'(1);
    chain_levels = (mc1 > (LVL_W + 1)'(MAX_LEVELS)) ? (LVL_W + 1)'(MAX_LEVELS) : mc1;
  end

  // table build datapath: pitch, area, size, running sum
  always_ff @(posedge clk) begin
    if (busy && !cfg_wr) begin
      case (seq_phase)
        PH_PITCH: begin
          seq_pitch          <= pitch_calc;
          pitch_tab[seq_lvl] <= pitch_calc;
          seq_hl             <= hl;
          seq_dl             <= dl;
        end
        PH_AREA: begin
          seq_area <= PH_W'(seq_pitch) * PH_W'(seq_hl);
        end
        PH_SIZE: begin
          seq_size <= SZ_W'(seq_area) * SZ_W'(seq_dl);
        end
        PH_ACCUM: begin
          // only the first MAX_LEVELS levels count towards chain sizes
          if (lvl_ext < (LVL_W + 1)'(MAX_LEVELS)) begin
            acc             <= acc_next;
            pfx_tab[wr_idx] <= acc_next;
            if (wr_ext == chain_levels) begin
              chain_total <= acc_next;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // item pipeline: lookup, multiply, partial sums, final sum
  // --------------------------------------------------------------------------
  assign adv       = !s4_valid || rsp.ready;
  assign req.ready = adv && !busy;

  always_comb begin
    x_in  = regs.block_compressed ? (req.texel_x >> 2) : req.texel_x;
    y_in  = regs.block_compressed ? (req.texel_y >> 2) : req.texel_y;
    m_ext = {1'b0, req.mip_level};
    pidx  = (m_ext > (LVL_W + 1)'(MAX_LEVELS)) ? PFX_IW'(MAX_LEVELS) : PFX_IW'(m_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req.valid && req.ready;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: table lookup
      s1_x     <= x_in;
      s1_y     <= y_in;
      s1_z     <= req.slice_index;
      s1_pitch <= pitch_tab[req.mip_level];
      s1_pfx   <= (pidx == '0) ? '0 : pfx_tab[pidx];

      // stage 2: products, chain times slice split in two halves
      s2_yp    <= (COORD_W + PITCH_W)'(s1_y) * (COORD_W + PITCH_W)'(s1_pitch);
      s2_xb    <= (COORD_W + BPP_W - 3)'(((COORD_W + BPP_W)'(s1_x)
                    * (COORD_W + BPP_W)'(regs.bits_per_texel)) >> 3);
      s2_zlo   <= (SPLIT_W + SLICE_W)'(chain_total[SPLIT_W-1:0])
                  * (SPLIT_W + SLICE_W)'(s1_z);
      s2_zhi   <= (SUM_W - SPLIT_W + SLICE_W)'(chain_total[SUM_W-1:SPLIT_W])
                  * (SUM_W - SPLIT_W + SLICE_W)'(s1_z);
      s2_pfx   <= s1_pfx;
      s2_pitch <= s1_pitch;

      // stage 3: partial sums
      s3_a     <= OFF_W'(s2_zlo) + (OFF_W'(s2_zhi) << SPLIT_W);
      s3_b     <= OFF_W'(s2_pfx) + OFF_W'(s2_yp);
      s3_xb    <= s2_xb;
      s3_pitch <= s2_pitch;

      // stage 4: output register, wraps at the offset width
      s4_off   <= s3_a + s3_b + OFF_W'(s3_xb);
      s4_row   <= s3_pitch[ROW_W-1:0];
    end
  end

  assign rsp.valid       = s4_valid;
  assign rsp.byte_offset = s4_off;
  assign rsp.row_bytes   = s4_row;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `MCTO_ASSERT_IMP(a_no_req_while_building, clk, rst, busy, !req.ready)
  `MCTO_ASSERT_NXT(a_cfg_restarts_build, clk, rst, cfg.valid && cfg.ready, busy)
  `MCTO_ASSERT_NXT(a_build_ends, clk, rst,
    busy && !cfg.valid && seq_phase == PH_ACCUM && seq_lvl == LVL_LAST, !busy)
  `MCTO_ASSERT_NXT(a_accept_enters_pipe, clk, rst, req.valid && req.ready, s1_valid)

endmodule
